[rtl/assert_macros.svh]
// Assertion macros shared by the tracker RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent holds -> consequent holds in the same cycle
`define PST_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("pst assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define PST_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("pst assertion failed");
`else
`define PST_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define PST_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

[rtl/pst_pkg.sv]
// Shared types and constants for the per-source sequence tracker.
// No dependencies; used by pst_ctrl, pst_dp and the top level.
package pst_pkg;

    localparam int SRC_W       = 10;
    localparam int SEQ_W       = 32;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 3;
    localparam int CNT_OUT_W   = 11;
    localparam int S_TDATA_W   = 48;
    localparam int S_PAD_W     = S_TDATA_W - SRC_W - SEQ_W;
    localparam int M_TDATA_W   = 120;
    localparam int M_PAD_W     = M_TDATA_W - SRC_W - 3 * SEQ_W - CNT_OUT_W;
    // source index reduction: q = (src * ceil(2^SHIFT / N)) >> SHIFT
    localparam int RECIP_SHIFT = 20;
    localparam int MOD_W       = 28;

    localparam int DEF_WINDOW_BITS = 64;
    localparam int DEF_NUM_SOURCES = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_TRACK     = 2'd0,
        OP_CLEAR_ONE = 2'd1,
        OP_CLEAR_ALL = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        K_FIRST   = 3'd0,
        K_OK      = 3'd1,
        K_GAP     = 3'd2,
        K_DUP     = 3'd3,
        K_REORDER = 3'd4,
        K_CLEARED = 3'd5
    } kind_t;

    typedef struct packed {
        logic capture;     // take the input transfer into the datapath
        logic load_idx;    // register the reduced table index
        logic exec;        // update the record and load the result register
        logic sweep_step;  // clear one table entry
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_none;
        logic op_clear_all;
        logic sweep_last;
        logic out_stall;   // result register full and not being taken
    } dp_status_t;

endpackage

[rtl/pst_ctrl.sv]
// Sequencer for the per-source sequence tracker.
// Depends on pst_pkg (command and status structs).
module pst_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  pst_pkg::dp_status_t    status,
    output pst_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_INDEX = 5'b00100,
        ST_READ  = 5'b01000,
        ST_EXEC  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                // undefined op: dropped without a result
                if (status.op_none)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.load_idx = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!status.out_stall)
                begin
                    cmd.exec   = 1'b1;
                    state_next = status.op_clear_all ? ST_SWEEP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

endmodule

[rtl/pst_dp.sv]
// Datapath for the per-source sequence tracker: index reduction, record
// memory, window update, active count and result register. Depends on pst_pkg.
module pst_dp
#(
    parameter int WINDOW_BITS = pst_pkg::DEF_WINDOW_BITS,
    parameter int NUM_SOURCES = pst_pkg::DEF_NUM_SOURCES,
    parameter int CNT_W       = $clog2(NUM_SOURCES + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pst_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [pst_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pst_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [pst_pkg::KIND_W-1:0]    m_tuser,
    input  pst_pkg::ctrl_cmd_t            cmd,
    output pst_pkg::dp_status_t           status,
    output logic [CNT_W-1:0]              active_count
);

    localparam int IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int REC_W   = 1 + pst_pkg::SEQ_W + WINDOW_BITS;
    localparam int RECIP   = ((1 << pst_pkg::RECIP_SHIFT) + NUM_SOURCES - 1) / NUM_SOURCES;
    localparam int PROD1_W = pst_pkg::SRC_W + pst_pkg::RECIP_SHIFT + 1;
    localparam int SEQ_W   = pst_pkg::SEQ_W;
    localparam logic [WINDOW_BITS-1:0] WIN_TOP = {1'b1, {(WINDOW_BITS-1){1'b0}}};

    // captured item
    pst_pkg::op_t              op_reg;
    logic [pst_pkg::SRC_W-1:0] src_reg;
    logic [SEQ_W-1:0]          seq_reg;
    logic [pst_pkg::SRC_W-1:0] q_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          sweep_cnt_reg;
    logic [CNT_W-1:0]          cnt_reg;

    // record memory: {valid, next expected, window}
    logic [REC_W-1:0]          rec_mem [NUM_SOURCES];
    logic [REC_W-1:0]          rd_data_reg;

    // result register
    logic                            out_valid_reg;
    pst_pkg::kind_t                  kind_reg;
    logic [pst_pkg::SRC_W-1:0]       src_out_reg;
    logic [SEQ_W-1:0]                exp_out_reg;
    logic [SEQ_W-1:0]                seq_out_reg;
    logic [SEQ_W-1:0]                gap_out_reg;
    logic [pst_pkg::CNT_OUT_W-1:0]   act_out_reg;

    logic [pst_pkg::SRC_W-1:0] src_in;
    logic [SEQ_W-1:0]          seq_in;
    logic [PROD1_W-1:0]        prod1;
    logic [pst_pkg::MOD_W-1:0] prod2;
    logic [pst_pkg::MOD_W-1:0] src_ext;
    logic [pst_pkg::MOD_W-1:0] rem;

    logic                      rec_valid;
    logic [SEQ_W-1:0]          rec_nx;
    logic [WINDOW_BITS-1:0]    rec_win;
    logic [SEQ_W-1:0]          gap_diff;
    logic [SEQ_W:0]            shift_amt;
    logic [SEQ_W-1:0]          age;
    logic [WINDOW_BITS-1:0]    age_bit;

    pst_pkg::kind_t            kind_c;
    logic [SEQ_W-1:0]          exp_c;
    logic [SEQ_W-1:0]          seq_c;
    logic [SEQ_W-1:0]          gap_c;
    logic                      rec_we;
    logic [REC_W-1:0]          rec_wdata;
    logic [CNT_W-1:0]          cnt_next;
    logic [CNT_W+pst_pkg::CNT_OUT_W-1:0] cnt_ext;

    assign src_in = s_tdata[pst_pkg::SRC_W-1:0];
    assign seq_in = s_tdata[pst_pkg::SRC_W +: SEQ_W];

    // quotient estimate is floor(src/N) or one more
    assign prod1   = PROD1_W'(src_in) * PROD1_W'(RECIP);
    assign prod2   = pst_pkg::MOD_W'(q_reg) * pst_pkg::MOD_W'(NUM_SOURCES);
    assign src_ext = pst_pkg::MOD_W'(src_reg);
    assign rem     = (prod2 > src_ext) ? (src_ext + pst_pkg::MOD_W'(NUM_SOURCES) - prod2)
                                       : (src_ext - prod2);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= pst_pkg::op_t'(s_tuser);
            src_reg <= src_in;
            seq_reg <= seq_in;
            q_reg   <= prod1[pst_pkg::RECIP_SHIFT +: pst_pkg::SRC_W];
        end
        if (cmd.load_idx)
        begin
            idx_reg <= rem[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            rec_mem[sweep_cnt_reg] <= '0;
        end
        else if (cmd.exec && rec_we)
        begin
            rec_mem[idx_reg] <= rec_wdata;
        end
        rd_data_reg <= rec_mem[idx_reg];
    end

    assign rec_valid = rd_data_reg[REC_W-1];
    assign rec_nx    = rd_data_reg[WINDOW_BITS +: SEQ_W];
    assign rec_win   = rd_data_reg[WINDOW_BITS-1:0];
    assign gap_diff  = seq_reg - rec_nx;
    assign shift_amt = {1'b0, gap_diff} + 1'b1;
    assign age       = rec_nx - seq_reg;
    // age 1 is the top bit, older numbers sit lower
    assign age_bit   = WIN_TOP >> (age - 1'b1);

    always_comb
    begin
        kind_c    = pst_pkg::K_CLEARED;
        exp_c     = '0;
        seq_c     = '0;
        gap_c     = '0;
        rec_we    = 1'b0;
        rec_wdata = rd_data_reg;
        cnt_next  = cnt_reg;
        unique case (op_reg)
            pst_pkg::OP_TRACK:
            begin
                seq_c = seq_reg;
                if (!rec_valid)
                begin
                    kind_c    = pst_pkg::K_FIRST;
                    rec_we    = 1'b1;
                    rec_wdata = {1'b1, seq_reg + 1'b1, {WINDOW_BITS{1'b0}}};
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    exp_c = rec_nx;
                    if (seq_reg >= rec_nx)
                    begin
                        // equal is a shift by one, same as a gap of zero
                        kind_c    = (seq_reg == rec_nx) ? pst_pkg::K_OK : pst_pkg::K_GAP;
                        gap_c     = gap_diff;
                        rec_we    = 1'b1;
                        rec_wdata = {1'b1, seq_reg + 1'b1, (rec_win >> shift_amt) | WIN_TOP};
                    end
                    else if (age <= SEQ_W'(WINDOW_BITS))
                    begin
                        if ((rec_win & age_bit) != '0)
                        begin
                            kind_c = pst_pkg::K_DUP;
                        end
                        else
                        begin
                            kind_c    = pst_pkg::K_REORDER;
                            rec_we    = 1'b1;
                            rec_wdata = {1'b1, rec_nx, rec_win | age_bit};
                        end
                    end
                    else
                    begin
                        kind_c = pst_pkg::K_REORDER;
                    end
                end
            end
            pst_pkg::OP_CLEAR_ONE:
            begin
                if (rec_valid)
                begin
                    rec_we    = 1'b1;
                    rec_wdata = {1'b0, rd_data_reg[REC_W-2:0]};
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            pst_pkg::OP_CLEAR_ALL:
            begin
                // table entries are cleared by the sweep that follows
                cnt_next = '0;
            end
            pst_pkg::OP_NONE:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign cnt_ext = {{pst_pkg::CNT_OUT_W{1'b0}}, cnt_next};

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            kind_reg    <= kind_c;
            src_out_reg <= src_reg;
            exp_out_reg <= exp_c;
            seq_out_reg <= seq_c;
            gap_out_reg <= gap_c;
            act_out_reg <= cnt_ext[pst_pkg::CNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {{pst_pkg::M_PAD_W{1'b0}}, act_out_reg, gap_out_reg,
                       seq_out_reg, exp_out_reg, src_out_reg};

    assign status.op_none      = (op_reg == pst_pkg::OP_NONE);
    assign status.op_clear_all = (op_reg == pst_pkg::OP_CLEAR_ALL);
    assign status.sweep_last   = (sweep_cnt_reg == IDX_W'(NUM_SOURCES - 1));
    assign status.out_stall    = out_valid_reg && !m_tready;

    assign active_count = cnt_reg;

endmodule

[rtl/per_source_sequence_tracker.sv]
// Channel   Dir  Payload
// s_axis    in   tuser: op; tdata: source, seq_number
// m_axis    out  tuser: kind; tdata: source_out, expected_before, seq_out,
//                gap_length, active_sources
//
// Track and clear-one items: capture, index reduction, record memory read and
// update, in that order; the record memory read is registered. Undefined op:
// dropped at index reduction, no result. Clear-all: result, then a sweep of
// every record memory entry with s_tready low; the same sweep runs after reset.
// A pending result does not block the next transfer; the update waits for it.
// Depends on pst_pkg, pst_ctrl, pst_dp and assert_macros.svh.
`include "assert_macros.svh"

module per_source_sequence_tracker
#(
    parameter int WINDOW_BITS = pst_pkg::DEF_WINDOW_BITS,
    parameter int NUM_SOURCES = pst_pkg::DEF_NUM_SOURCES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [9:0] source, [41:10] seq_number, rest zero
    input  logic [pst_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] op
    input  logic [pst_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [9:0] source_out, [41:10] expected_before, [73:42] seq_out,
    // [105:74] gap_length, [116:106] active_sources, rest zero
    output logic [pst_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] kind
    output logic [pst_pkg::KIND_W-1:0]    m_tuser
);

    localparam int CNT_W = $clog2(NUM_SOURCES + 1);

    pst_pkg::ctrl_cmd_t  cmd;
    pst_pkg::dp_status_t status;
    logic [CNT_W-1:0]    active_count;

    pst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pst_dp
    #(
        .WINDOW_BITS (WINDOW_BITS),
        .NUM_SOURCES (NUM_SOURCES),
        .CNT_W       (CNT_W)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cmd          (cmd),
        .status       (status),
        .active_count (active_count)
    );

    `PST_ASSERT_IMP(a_no_accept_in_sweep, clk, rst_n, cmd.sweep_step, !s_tready)
    `PST_ASSERT_IMP(a_exec_needs_room, clk, rst_n, cmd.exec, !(m_tvalid && !m_tready))
    `PST_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, active_count <= CNT_W'(NUM_SOURCES))
    `PST_ASSERT_NXT(a_clear_all_zero, clk, rst_n, cmd.exec && status.op_clear_all,
                    active_count == '0)

endmodule

[tb/per_source_sequence_tracker_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for per_source_sequence_tracker: directed and random
// track/clear traffic, predicted per source and compared field by field.
// Depends on pst_pkg and the per_source_sequence_tracker RTL.

module per_source_sequence_tracker_tb;

    localparam int WIN        = 64;
    localparam int N_SRC      = 1024;
    localparam int RAND_ITEMS = 1600;
    localparam int LIMIT      = 400000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 20;

    typedef struct {
        pst_pkg::op_t                op;
        logic [pst_pkg::SRC_W-1:0]   src;
        logic [pst_pkg::SEQ_W-1:0]   seq;
    } pkt_t;

    typedef struct {
        pst_pkg::kind_t                kind;
        logic [pst_pkg::SRC_W-1:0]     src;
        logic [pst_pkg::SEQ_W-1:0]     exp_before;
        logic [pst_pkg::SEQ_W-1:0]     seq;
        logic [pst_pkg::SEQ_W-1:0]     gap;
        logic [pst_pkg::CNT_OUT_W-1:0] active;
    } verdict_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pst_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [pst_pkg::OP_W-1:0]      s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pst_pkg::M_TDATA_W-1:0] m_tdata;
    logic [pst_pkg::KIND_W-1:0]    m_tuser;

    per_source_sequence_tracker uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // predicted per-source records
    bit                        rec_valid [N_SRC];
    logic [pst_pkg::SEQ_W-1:0] rec_next  [N_SRC];
    logic [WIN-1:0]            rec_seen  [N_SRC];
    int                        live_sources;

    pkt_t     pending_pkts[$];
    verdict_t verdict_q[$];
    pkt_t     cur_pkt;
    logic     taken = 1'b0;
    int       total_pkts;
    int       sent_cnt;
    int       errors;
    int       cycles;
    int       kind_seen[6];
    int       send_idle;
    int       recv_idle;
    int       hold_cnt;
    bit       hold_done;

    function automatic bit track_record(input pkt_t p, output verdict_t v);
        logic [pst_pkg::SEQ_W-1:0] nx;
        logic [pst_pkg::SEQ_W-1:0] age;
        logic [pst_pkg::SEQ_W:0]   sh;
        logic [WIN-1:0]            w;
        logic [WIN-1:0]            bit_m;
        int                        idx;
        idx = p.src % N_SRC;
        v.src        = p.src;
        v.exp_before = '0;
        v.seq        = '0;
        v.gap        = '0;
        v.kind       = pst_pkg::K_CLEARED;
        if (p.op == pst_pkg::OP_NONE)
            return 1'b0;
        if (p.op == pst_pkg::OP_CLEAR_ALL)
        begin
            foreach (rec_valid[i]) rec_valid[i] = 1'b0;
            live_sources = 0;
        end
        else if (p.op == pst_pkg::OP_CLEAR_ONE)
        begin
            if (rec_valid[idx])
            begin
                rec_valid[idx] = 1'b0;
                live_sources--;
            end
        end
        else if (!rec_valid[idx])
        begin
            rec_valid[idx] = 1'b1;
            live_sources++;
            rec_next[idx] = p.seq + 1;
            rec_seen[idx] = '0;
            v.kind = pst_pkg::K_FIRST;
            v.seq  = p.seq;
        end
        else
        begin
            nx = rec_next[idx];
            w  = rec_seen[idx];
            v.exp_before = nx;
            v.seq        = p.seq;
            if (p.seq == nx)
            begin
                rec_seen[idx] = (w >> 1) | (64'h1 << (WIN - 1));
                rec_next[idx] = p.seq + 1;
                v.kind = pst_pkg::K_OK;
            end
            else if (p.seq > nx)
            begin
                v.gap = p.seq - nx;
                sh = {1'b0, v.gap} + 33'd1;
                if (sh >= WIN)
                    w = '0;
                else
                    w = w >> sh[5:0];
                rec_seen[idx] = w | (64'h1 << (WIN - 1));
                rec_next[idx] = p.seq + 1;
                v.kind = pst_pkg::K_GAP;
            end
            else
            begin
                age = nx - p.seq;
                v.kind = pst_pkg::K_REORDER;
                if (age <= WIN)
                begin
                    bit_m = 64'h1 << (WIN - age);
                    if ((w & bit_m) != 0)
                        v.kind = pst_pkg::K_DUP;
                    else
                        rec_seen[idx] = w | bit_m;
                end
            end
        end
        v.active = live_sources[pst_pkg::CNT_OUT_W-1:0];
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [pst_pkg::SEQ_W-1:0] want,
                               input logic [pst_pkg::SEQ_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic add_pkt(input pst_pkg::op_t op, input logic [pst_pkg::SRC_W-1:0] src,
                           input logic [pst_pkg::SEQ_W-1:0] seq);
        pkt_t p;
        p.op  = op;
        p.src = src;
        p.seq = seq;
        pending_pkts.push_back(p);
    endtask

    // idle mix follows progress through the stimulus
    always_comb
    begin
        if (sent_cnt < total_pkts / 3)
        begin
            send_idle = 13;
            recv_idle = 64;
        end
        else if (sent_cnt < (2 * total_pkts) / 3)
        begin
            send_idle = 64;
            recv_idle = 13;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || taken)
        begin
            if (pending_pkts.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                cur_pkt  <= pending_pkts[0];
                s_tvalid <= 1'b1;
                s_tuser  <= pending_pkts[0].op;
                s_tdata  <= {{pst_pkg::S_PAD_W{1'b0}}, pending_pkts[0].seq,
                             pending_pkts[0].src};
                void'(pending_pkts.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off in the last phase
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (!hold_done && sent_cnt >= (2 * total_pkts) / 3)
        begin
            m_tready  <= 1'b0;
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin : monitor
        verdict_t v;
        verdict_t want;
        if (rst_n)
        begin
            taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                sent_cnt++;
                if (track_record(cur_pkt, v))
                    verdict_q.push_back(v);
            end
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transfer with no prediction pending");
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_tuser));
                    check_field("source_out", 32'(want.src), 32'(m_tdata[9:0]));
                    check_field("expected_before", want.exp_before, m_tdata[41:10]);
                    check_field("seq_out", want.seq, m_tdata[73:42]);
                    check_field("gap_length", want.gap, m_tdata[105:74]);
                    check_field("active_sources", 32'(want.active),
                                32'(m_tdata[116:106]));
                    if (m_tuser < 6)
                        kind_seen[m_tuser]++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("per_source_sequence_tracker_tb: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [pst_pkg::SRC_W-1:0] pool[16];
        logic [pst_pkg::SEQ_W-1:0] gen_next[N_SRC];
        bit                        gen_known[N_SRC];
        logic [pst_pkg::SRC_W-1:0] src;
        logic [pst_pkg::SEQ_W-1:0] seq;
        int                        r;
        int                        counted;

        sent_cnt = 0;
        errors = 0;
        cycles = 0;
        live_sources = 0;
        foreach (rec_valid[i]) rec_valid[i] = 1'b0;
        foreach (gen_known[i]) gen_known[i] = 1'b0;

        // directed: window edges, wrap, clears, ignored op
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd0);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd1);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd1);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd5);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd3);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd3);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd69);      // gap+1 equals window: flush
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd6);       // oldest slot in window
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd5);       // just past the window
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd132);     // gap+1 one short of window
        add_pkt(pst_pkg::OP_TRACK, 10'd1023, 32'hFFFF_FFFF);
        add_pkt(pst_pkg::OP_TRACK, 10'd1023, 32'd0);    // wraps to zero
        add_pkt(pst_pkg::OP_TRACK, 10'd1023, 32'hFFFF_FFFF);
        add_pkt(pst_pkg::OP_TRACK, 10'd1023, 32'h8000_0000);
        add_pkt(pst_pkg::OP_TRACK, 10'd512, 32'h1234_5678);
        add_pkt(pst_pkg::OP_NONE, 10'd512, 32'h1234_5679);
        add_pkt(pst_pkg::OP_CLEAR_ONE, 10'd512, 32'hFFFF_FFFF);
        add_pkt(pst_pkg::OP_CLEAR_ONE, 10'd512, 32'd0); // already invalid
        add_pkt(pst_pkg::OP_TRACK, 10'd512, 32'd7);
        add_pkt(pst_pkg::OP_CLEAR_ALL, 10'h2AA, 32'hAAAA_AAAA);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'hFFFF_FFFF);
        add_pkt(pst_pkg::OP_TRACK, 10'd0, 32'd0);
        add_pkt(pst_pkg::OP_TRACK, 10'h155, 32'hAAAA_AAAA);
        add_pkt(pst_pkg::OP_TRACK, 10'h155, 32'h5555_5555);
        add_pkt(pst_pkg::OP_NONE, 10'd1023, 32'hFFFF_FFFF);

        foreach (pool[i]) pool[i] = pst_pkg::SRC_W'($urandom_range(N_SRC - 1));
        pool[0] = 10'd1023;

        counted = 0;
        while (counted < RAND_ITEMS)
        begin
            if ($urandom_range(99) < 85)
                src = pool[$urandom_range(15)];
            else
                src = pst_pkg::SRC_W'($urandom_range(N_SRC - 1));
            r = $urandom_range(999);
            if (r < 30)
            begin
                add_pkt(pst_pkg::OP_CLEAR_ONE, src, $urandom);
                gen_known[src] = 1'b0;
                counted++;
            end
            else if (r < 33)
            begin
                add_pkt(pst_pkg::OP_CLEAR_ALL, src, $urandom);
                foreach (gen_known[i]) gen_known[i] = 1'b0;
                counted++;
            end
            else if (r < 50)
            begin
                add_pkt(pst_pkg::OP_NONE, src, $urandom);
            end
            else
            begin
                if (!gen_known[src])
                begin
                    seq = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15)
                                                   : $urandom;
                    gen_next[src] = seq + 1;
                    gen_known[src] = 1'b1;
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 55)
                        seq = gen_next[src];
                    else if (r < 70)
                        seq = gen_next[src] + $urandom_range(70, 1);
                    else if (r < 88)
                        seq = gen_next[src] - $urandom_range(66, 1);
                    else if (r < 92)
                        seq = gen_next[src] - $urandom_range(100000, 67);
                    else
                        seq = $urandom;
                    if (r < 70 || r >= 92)
                        gen_next[src] = seq + 1;
                end
                add_pkt(pst_pkg::OP_TRACK, src, seq);
                counted++;
            end
        end
        total_pkts = pending_pkts.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_pkts.size() != 0 || s_tvalid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", verdict_q.size());
            errors++;
        end

        $display("Sent %0d items; results first %0d ok %0d gap %0d dup %0d reorder %0d",
                 sent_cnt, kind_seen[pst_pkg::K_FIRST], kind_seen[pst_pkg::K_OK],
                 kind_seen[pst_pkg::K_GAP], kind_seen[pst_pkg::K_DUP],
                 kind_seen[pst_pkg::K_REORDER]);
        $display("cleared %0d, with both-side stalls and a %0d-cycle output hold-off",
                 kind_seen[pst_pkg::K_CLEARED], HOLD_LEN);
        if (errors == 0)
        begin
            $display("per_source_sequence_tracker_tb: PASS");
        end
        else
        begin
            $display("per_source_sequence_tracker_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_ctrl.sv
rtl/pst_dp.sv
rtl/per_source_sequence_tracker.sv
tb/per_source_sequence_tracker_tb.sv
